>>> design/vha_pkg.sv
// ----------------------------------------------------------------------------
// vha_pkg
// Shared types, codes and default sizes for the versioned handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vha_pkg;

    // Default sizing of the handle table.
    localparam int VHA_GROUP_SIZE     = 16;
    localparam int VHA_INITIAL_GROUPS = 2;
    localparam int VHA_MAX_ENTRIES    = 256;

    // Fixed field widths of the request and result transfers.
    localparam int ACTION_W = 2;
    localparam int ID_W     = 8;
    localparam int GEN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Request action codes. Code 3 is treated as a lookup.
    localparam logic [ACTION_W-1:0] ACT_CREATE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     handle_id;
        logic [GEN_W-1:0]    handle_generation;
    } vha_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     out_id;
        logic [GEN_W-1:0]    out_generation;
        logic [COUNT_W-1:0]  in_use_count;
    } vha_result_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GROW,
        ST_READ,
        ST_EXEC
    } vha_state_t;

endpackage : vha_pkg

`default_nettype wire

>>> design/vha_ram.sv
// ----------------------------------------------------------------------------
// vha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule : vha_ram

`default_nettype wire

>>> design/versioned_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// versioned_handle_allocator_core
// Handle table with a LIFO free list and a generation number per entry.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Create, remove and
// lookup keep busy high until the write-back is done: the accepting cycle
// reads the link and entry memories, the next modifies and writes them back.
// The result appears on result for exactly one cycle with done high, the
// cycle after the write-back, and cannot be held off. A create that finds the
// free list empty while capacity remains first links a new group of n entries
// (GROUP_SIZE or the remainder) one per cycle, then reads the new list head
// before it executes. After reset the block is busy while it links the first
// INITIAL_GROUPS * GROUP_SIZE entries (capped at MAX_ENTRIES).
// ----------------------------------------------------------------------------
`default_nettype none

module versioned_handle_allocator_core
    import vha_pkg::*;
#(
    parameter int GROUP_SIZE     = VHA_GROUP_SIZE,
    parameter int INITIAL_GROUPS = VHA_INITIAL_GROUPS,
    parameter int MAX_ENTRIES    = VHA_MAX_ENTRIES
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire vha_request_t request,
    output logic              done,
    output vha_result_t       result
);

    localparam int ADDR_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W        = (CNT_W > ID_W) ? CNT_W : ID_W;
    localparam int GROUP_N      = (GROUP_SIZE < MAX_ENTRIES) ? GROUP_SIZE : MAX_ENTRIES;
    localparam int INIT_RAW     = INITIAL_GROUPS * GROUP_SIZE;
    localparam int INIT_ENTRIES = (INIT_RAW > MAX_ENTRIES) ? MAX_ENTRIES : INIT_RAW;
    localparam int ENTRY_W      = GEN_W + 1;

    localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_ENTRIES);

    // Control and bookkeeping registers.
    vha_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  free_head_reg, free_head_next;
    logic [CNT_W-1:0]  issued_reg, issued_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] first_reg, first_next;
    logic              done_reg, done_next;
    vha_request_t      req_reg, req_next;
    vha_result_t       result_reg, result_next;

    // Memory ports.
    logic              link_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  link_wdata;
    logic [CNT_W-1:0]  link_rdata;
    logic              entry_we;
    logic [ENTRY_W-1:0] entry_wdata;
    logic [ENTRY_W-1:0] entry_rdata;
    logic [ADDR_W-1:0] rd_addr;

    // Decoded helpers.
    logic              accept;
    logic              is_create;
    logic              is_remove;
    logic              list_empty;
    logic              sweep_last;
    logic [CNT_W-1:0]  remain;
    logic [CNT_W-1:0]  grow_n;
    logic [ADDR_W-1:0] req_addr;
    logic [ADDR_W-1:0] head_addr;
    logic              id_issued;
    logic              entry_in_use;
    logic [GEN_W-1:0]  entry_gen;
    logic [GEN_W-1:0]  gen_inc;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign is_create  = (request.action == ACT_CREATE);
    assign list_empty = (free_head_reg == NULL_LINK);
    assign remain     = NULL_LINK - issued_reg;
    assign grow_n     = (remain > CNT_W'(GROUP_N)) ? CNT_W'(GROUP_N) : remain;
    assign sweep_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == issued_reg);
    assign head_addr  = free_head_reg[ADDR_W-1:0];
    assign req_addr   = ADDR_W'(req_reg.handle_id);
    assign is_remove  = (req_reg.action == ACT_REMOVE);
    assign id_issued  = (CMP_W'(req_reg.handle_id) < CMP_W'(issued_reg));
    assign entry_in_use = entry_rdata[GEN_W];
    assign entry_gen    = entry_rdata[GEN_W-1:0];
    assign gen_inc      = entry_gen + GEN_W'(1);

    // Link memory: next free entry, or the null link.
    vha_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (wr_addr),
        .wr_data (link_wdata),
        .rd_addr (rd_addr),
        .rd_data (link_rdata)
    );

    // Entry memory: in-use flag over the generation number.
    vha_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_we),
        .wr_addr (wr_addr),
        .wr_data (entry_wdata),
        .rd_addr (rd_addr),
        .rd_data (entry_rdata)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (is_create && list_empty && (issued_reg != NULL_LINK))
                    begin
                        state_next = ST_GROW;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_GROW:
            begin
                if (sweep_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory read address: the request's entry at acceptance of a remove or
    // lookup, else the free list head, read for a create and after a growth sweep.
    always_comb
    begin
        if (state_reg == ST_IDLE && !is_create)
        begin
            rd_addr = ADDR_W'(request.handle_id);
        end
        else
        begin
            rd_addr = head_addr;
        end
    end

    // Memory writes: link sweep during clear and growth, write-back in execute.
    always_comb
    begin
        link_we     = 1'b0;
        entry_we    = 1'b0;
        wr_addr     = ptr_reg;
        link_wdata  = NULL_LINK;
        entry_wdata = '0;
        unique case (state_reg)
            ST_CLEAR, ST_GROW:
            begin
                link_we    = 1'b1;
                entry_we   = 1'b1;
                link_wdata = (ptr_reg == first_reg) ? NULL_LINK
                                                    : (CNT_W'(ptr_reg) - CNT_W'(1));
            end
            ST_EXEC:
            begin
                if (req_reg.action == ACT_CREATE)
                begin
                    wr_addr     = head_addr;
                    link_wdata  = NULL_LINK;
                    entry_wdata = {1'b1, entry_gen};
                    link_we     = !list_empty;
                    entry_we    = !list_empty;
                end
                else if (is_remove)
                begin
                    wr_addr     = req_addr;
                    link_wdata  = free_head_reg;
                    entry_wdata = {1'b0, gen_inc};
                    link_we     = id_issued && entry_in_use;
                    entry_we    = id_issued && entry_in_use;
                end
            end
            default:
            begin
                link_we  = 1'b0;
                entry_we = 1'b0;
            end
        endcase
    end

    // Bookkeeping updates and the result word.
    always_comb
    begin
        free_head_next = free_head_reg;
        issued_next    = issued_reg;
        used_next      = used_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        req_next       = req_reg;
        result_next    = result_reg;
        done_next      = 1'b0;

        // Sweep pointer walks the group being linked.
        if (state_reg == ST_CLEAR || state_reg == ST_GROW)
        begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end

        // Latch the request; a create on an empty list with capacity left claims a new group.
        if (accept)
        begin
            req_next = request;
            if (is_create && list_empty && (issued_reg != NULL_LINK))
            begin
                ptr_next       = ADDR_W'(issued_reg);
                first_next     = ADDR_W'(issued_reg);
                issued_next    = issued_reg + grow_n;
                free_head_next = issued_reg + grow_n - CNT_W'(1);
            end
        end

        // Execute against the entry read in the previous cycle.
        if (state_reg == ST_EXEC)
        begin
            done_next                  = 1'b1;
            result_next.status         = STATUS_OK;
            result_next.out_id         = req_reg.handle_id;
            result_next.out_generation = '0;
            if (req_reg.action == ACT_CREATE)
            begin
                if (list_empty)
                begin
                    result_next.status = STATUS_FULL;
                    result_next.out_id = '0;
                end
                else
                begin
                    free_head_next             = link_rdata;
                    used_next                  = used_reg + CNT_W'(1);
                    result_next.out_id         = ID_W'(free_head_reg);
                    result_next.out_generation = entry_gen;
                end
            end
            else if (is_remove)
            begin
                if (id_issued && entry_in_use)
                begin
                    free_head_next             = CNT_W'(req_addr);
                    used_next                  = used_reg - CNT_W'(1);
                    result_next.out_generation = gen_inc;
                end
                else
                begin
                    result_next.status = STATUS_NOT_USED;
                end
            end
            else
            begin
                if (id_issued && entry_in_use && (entry_gen == req_reg.handle_generation))
                begin
                    result_next.out_generation = entry_gen;
                end
                else
                begin
                    result_next.status = STATUS_MISS;
                end
            end
            result_next.in_use_count = COUNT_W'(used_next);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            free_head_reg <= CNT_W'(INIT_ENTRIES - 1);
            issued_reg    <= CNT_W'(INIT_ENTRIES);
            used_reg      <= '0;
            ptr_reg       <= '0;
            first_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            issued_reg    <= issued_next;
            used_reg      <= used_next;
            ptr_reg       <= ptr_next;
            first_reg     <= first_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // A result transfer follows an execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result without execute cycle");

    // No more entries in use than have been issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= issued_reg)
        else $error("in-use count exceeds issued entries");

    // The free list head is null or an issued entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == NULL_LINK) || (free_head_reg < issued_reg))
        else $error("free list head outside issued range");

    // A create on an empty list with capacity left starts a growth sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_create && list_empty && (issued_reg != NULL_LINK))
            |=> (state_reg == ST_GROW))
        else $error("growth sweep not started");

    // In execute, the generation only changes through a successful remove.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && entry_we && !is_remove)
            |-> (entry_wdata[GEN_W-1:0] == entry_gen))
        else $error("generation changed outside remove");
`endif

endmodule : versioned_handle_allocator_core

`default_nettype wire

>>> tb/tb_versioned_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_versioned_handle_allocator_core
// Self-checking testbench for the versioned handle allocator.
// ----------------------------------------------------------------------------
// Requests are sent with the start/busy handshake. Every accepted transfer
// goes into a handle table tracker that keeps its own free list, generation
// and in-use state and queues the result it expects. Each result strobed by
// done is compared field by field against the oldest queued result. A short
// directed sequence covers the corner cases. A long random run follows,
// alternating between filling the table up to capacity and draining it again.
// Requests are mostly well-formed handles with some noise mixed in, under
// several sender idle rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_versioned_handle_allocator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import vha_pkg::*;

    localparam int GROUP_SIZE     = VHA_GROUP_SIZE;
    localparam int INITIAL_GROUPS = VHA_INITIAL_GROUPS;
    localparam int MAX_ENTRIES    = VHA_MAX_ENTRIES;
    localparam int RANDOM_PER_PHASE = 290;
    localparam int MAX_IDLE_GAP   = 24;
    localparam int DRAIN_CYCLES   = 32;
    localparam int CYCLE_LIMIT    = 400000;

    localparam logic [COUNT_W-1:0] NULL_LINK = COUNT_W'(MAX_ENTRIES);

    // Tracks the handle table and holds the results still to come.
    class handle_table_tracker;
        logic [COUNT_W-1:0] link_of [MAX_ENTRIES];
        logic [GEN_W-1:0]   gen_of [MAX_ENTRIES];
        bit                 used_of [MAX_ENTRIES];
        logic [COUNT_W-1:0] free_head;
        logic [COUNT_W-1:0] issued;
        logic [COUNT_W-1:0] used_total;
        vha_result_t        pending_results[$];
        int unsigned        errors;

        function new();
            int init_count;
            init_count = INITIAL_GROUPS * GROUP_SIZE;
            if (init_count > MAX_ENTRIES)
                init_count = MAX_ENTRIES;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                link_of[i] = NULL_LINK;
                gen_of[i]  = '0;
                used_of[i] = 1'b0;
            end
            link_group('0, COUNT_W'(init_count));
            issued     = COUNT_W'(init_count);
            used_total = '0;
            errors     = 0;
        endfunction

        // Chain ids first..first+n-1 onto an empty list, highest id on top.
        function void link_group(logic [COUNT_W-1:0] first, logic [COUNT_W-1:0] n);
            for (int k = 0; k < n; k++)
                link_of[first + k] = (k == 0) ? NULL_LINK : COUNT_W'(first + k - 1);
            free_head = (n == 0) ? NULL_LINK : COUNT_W'(first + n - 1);
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(vha_request_t req);
            vha_result_t        res;
            logic [COUNT_W-1:0] n;
            logic [COUNT_W-1:0] e;
            logic [COUNT_W-1:0] id;
            res    = '0;
            id     = COUNT_W'(req.handle_id);
            res.out_id = req.handle_id;
            if (req.action == ACT_CREATE)
            begin
                res.out_id = '0;
                // Grow by one group when the list is empty and room remains.
                if (free_head == NULL_LINK && issued < MAX_ENTRIES)
                begin
                    n = COUNT_W'(MAX_ENTRIES) - issued;
                    if (n > GROUP_SIZE)
                        n = COUNT_W'(GROUP_SIZE);
                    link_group(issued, n);
                    issued = issued + n;
                end
                if (free_head == NULL_LINK)
                    res.status = STATUS_FULL;
                else
                begin
                    e             = free_head;
                    free_head     = link_of[e];
                    link_of[e]    = NULL_LINK;
                    used_of[e]    = 1'b1;
                    used_total    = used_total + 1'b1;
                    res.status    = STATUS_OK;
                    res.out_id    = e[ID_W-1:0];
                    res.out_generation = gen_of[e];
                end
            end
            else if (req.action == ACT_REMOVE)
            begin
                if (id >= issued || !used_of[id])
                    res.status = STATUS_NOT_USED;
                else
                begin
                    used_of[id] = 1'b0;
                    gen_of[id]  = gen_of[id] + 1'b1;
                    link_of[id] = free_head;
                    free_head   = id;
                    used_total  = used_total - 1'b1;
                    res.status  = STATUS_OK;
                    res.out_generation = gen_of[id];
                end
            end
            else
            begin
                // Lookup; the undefined action code behaves the same way.
                if (id < issued && used_of[id] && gen_of[id] == req.handle_generation)
                begin
                    res.status = STATUS_OK;
                    res.out_generation = gen_of[id];
                end
                else
                    res.status = STATUS_MISS;
            end
            res.in_use_count = used_total;
            pending_results = {pending_results, res};
        endfunction

        function void compare_field(string name, logic [GEN_W-1:0] want,
                                    logic [GEN_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        endfunction

        // Compare one result transfer against the oldest queued result.
        function void check_result(vha_result_t got);
            vha_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result with none outstanding: 0x%0h", got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", GEN_W'(want.status), GEN_W'(got.status));
            compare_field("out_id", GEN_W'(want.out_id), GEN_W'(got.out_id));
            compare_field("out_generation", want.out_generation, got.out_generation);
            compare_field("in_use_count", GEN_W'(want.in_use_count),
                          GEN_W'(got.in_use_count));
        endfunction

        // Random id among the entries in use, or -1 when none is.
        function int pick_used_id();
            int ids[$];
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (used_of[i])
                    ids = {ids, i};
            if (ids.size() == 0)
                return -1;
            return ids[$urandom_range(ids.size() - 1)];
        endfunction
    endclass

    logic         clk     = 1'b0;
    logic         rst_n   = 1'b0;
    logic         start   = 1'b0;
    vha_request_t request = '0;
    logic         busy;
    logic         done;
    vha_result_t  result;

    handle_table_tracker table_sb = new();
    int unsigned         cycle_count = 0;
    bit                  filling = 1'b1;

    versioned_handle_allocator_core #(
        .GROUP_SIZE     (GROUP_SIZE),
        .INITIAL_GROUPS (INITIAL_GROUPS),
        .MAX_ENTRIES    (MAX_ENTRIES)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Clock generation.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[versioned_handle_allocator_core] ERROR");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
            table_sb.check_result(result);
    end

    function automatic vha_request_t make_request(logic [ACTION_W-1:0] action,
                                                  logic [ID_W-1:0] id,
                                                  logic [GEN_W-1:0] gen);
        vha_request_t r;
        r.action            = action;
        r.handle_id         = id;
        r.handle_generation = gen;
        return r;
    endfunction

    // Send one request after a random idle gap and wait for its transfer.
    task automatic send_request(input vha_request_t req, input int idle_pct);
        int           gap;
        vha_request_t junk;
        gap = 0;
        while (gap < MAX_IDLE_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            junk.action            = ACTION_W'($urandom);
            junk.handle_id         = ID_W'($urandom);
            junk.handle_generation = $urandom;
            start   <= 1'b0;
            request <= junk;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        table_sb.note_request(req);
    endtask

    // Random request: mostly valid handles, biased toward fill or drain.
    function automatic vha_request_t next_random_request();
        vha_request_t r;
        int           pick;
        int           uid;
        r.action            = ACT_LOOKUP;
        r.handle_id         = ID_W'($urandom_range(255));
        r.handle_generation = $urandom;
        pick = $urandom_range(99);
        uid  = table_sb.pick_used_id();
        if (pick < 10)
        begin
            // Noise: any action code, sometimes aimed at a live handle.
            r.action = ACTION_W'($urandom_range(3));
            if (uid >= 0 && $urandom_range(1))
            begin
                r.handle_id         = ID_W'(uid);
                r.handle_generation = table_sb.gen_of[uid];
            end
        end
        else if (pick < (filling ? 80 : 25))
            r.action = ACT_CREATE;
        else if (pick < (filling ? 88 : 85))
        begin
            r.action = ACT_REMOVE;
            if (uid >= 0)
                r.handle_id = ID_W'(uid);
        end
        else if (uid >= 0)
        begin
            // Lookup of a live id, now and then with a stale generation.
            r.handle_id         = ID_W'(uid);
            r.handle_generation = table_sb.gen_of[uid];
            if ($urandom_range(9) < 3)
                r.handle_generation = r.handle_generation - 1'b1;
        end
        return r;
    endfunction

    // Main stimulus.
    initial
    begin
        vha_request_t directed[$];
        int           idle_pct[4];
        idle_pct = '{0, 56, 0, 22};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corner cases.
        directed = {directed, make_request(ACT_LOOKUP, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_REMOVE, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_REMOVE, 8'd255, 32'hFFFF_FFFF)};
        directed = {directed, make_request(ACT_LOOKUP, 8'd255, 32'hFFFF_FFFF)};
        directed = {directed, make_request(ACT_CREATE, 8'd255, 32'hFFFF_FFFF)};
        directed = {directed, make_request(ACT_LOOKUP, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_LOOKUP, 8'd0, 32'hFFFF_FFFF)};
        directed = {directed, make_request(ACT_RESERVED, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_CREATE, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_REMOVE, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_REMOVE, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_LOOKUP, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_CREATE, 8'd0, 32'h0)};
        directed = {directed, make_request(ACT_LOOKUP, 8'd0, 32'h1)};
        directed = {directed, make_request(ACT_RESERVED, 8'hAA, 32'h5555_5555)};
        directed = {directed, make_request(ACT_LOOKUP, 8'd1, 32'hAAAA_AAAA)};
        directed = {directed, make_request(ACT_REMOVE, 8'd1, 32'h0)};
        directed = {directed, make_request(ACT_LOOKUP, 8'd40, 32'h0)};
        foreach (directed[i])
            send_request(directed[i], 0);

        // Random phases under different sender idle rates.
        foreach (idle_pct[p])
        begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (filling && table_sb.used_total == MAX_ENTRIES && $urandom_range(7) == 0)
                    filling = 1'b0;
                else if (!filling && table_sb.used_total < 8)
                    filling = 1'b1;
                send_request(next_random_request(), idle_pct[p]);
            end
        end
        start <= 1'b0;

        // Let outstanding results come back, then watch for strays.
        while (table_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (table_sb.errors == 0)
            $display("[versioned_handle_allocator_core] OK");
        else
            $display("[versioned_handle_allocator_core] ERROR");
        $finish;
    end

endmodule : tb_versioned_handle_allocator_core

`default_nettype wire
